>>> hdl/rtc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the RTU response checker.
package rtc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 9'd5;
  localparam logic [COUNT_W-1:0] EXC_FRAME_LEN = 9'd5;
  localparam logic [COUNT_W-1:0] WRITE_FRAME_LEN = 9'd8;
  localparam logic [COUNT_W-1:0] READ_HEADER_LEN = 9'd5;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
  localparam logic [6:0] READ_FC_RST = 7'd3;
  localparam logic [6:0] WRITE_FC_RST = 7'd16;
  localparam logic [7:0] EXC_FLAG_RST = 8'd128;

  localparam int CFG_INDEX_W = 2;
  localparam int OP_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_READ_FC    = 2'd1,
    CFG_WRITE_FC   = 2'd2,
    CFG_EXC_FLAG   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_EXCEPTION = 3'd3,
    ST_CRC_EXC   = 3'd4,
    ST_CRC_WRITE = 3'd5,
    ST_CRC_READ  = 3'd6,
    ST_UNKNOWN   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_EXC     = 2'd1,
    KIND_WRITE   = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CRC     = 2'd1,
    ACT_HOLD_LO = 2'd2,
    ACT_HOLD_HI = 2'd3
  } crc_act_t;

  typedef enum logic [2:0] {
    V_SHORT    = 3'd0,
    V_BAD_ADDR = 3'd1,
    V_EXC      = 3'd2,
    V_WRITE    = 3'd3,
    V_READ     = 3'd4,
    V_UNKNOWN  = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    crc_act_t   act;
    logic       last;
    verdict_t   verdict;
    logic [7:0] third;
    logic [7:0] data_high;
    logic [7:0] data_low;
  } op_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] exception_code;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic       data_valid;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/rtc_fifo.sv
// Small register-based first-in first-out queue with show-ahead read.
module rtc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/rtc_front.sv
// Front end: configuration registers, byte counting, header capture and frame classification.
module rtc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             in_last_byte,
  output logic                             op_push,
  output rtc_pkg::op_t                     op_data,
  input  logic                             op_full
);

  logic [7:0] slave_addr_r;
  logic [6:0] read_fc_r;
  logic [6:0] write_fc_r;
  logic [7:0] exc_flag_r;

  logic [rtc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [7:0] addr_r, func_r, third_r, data_high_r, data_low_r;
  logic [7:0] addr_cap, func_cap, third_cap, data_high_cap, data_low_cap;

  logic                        accept;
  logic [rtc_pkg::COUNT_W-1:0] n;
  logic [rtc_pkg::COUNT_W-1:0] total;
  logic [rtc_pkg::COUNT_W-1:0] len;
  logic [rtc_pkg::COUNT_W-1:0] len_m1;
  logic [rtc_pkg::COUNT_W-1:0] len_m2;
  rtc_pkg::kind_t              kind;
  rtc_pkg::crc_act_t           act;
  rtc_pkg::verdict_t           verdict;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !op_full;
  assign in_full   = op_full;
  assign op_push   = accept;
  assign n         = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= rtc_pkg::SLAVE_ADDR_RST;
      read_fc_r    <= rtc_pkg::READ_FC_RST;
      write_fc_r   <= rtc_pkg::WRITE_FC_RST;
      exc_flag_r   <= rtc_pkg::EXC_FLAG_RST;
    end else if (cfg_valid) begin
      unique case (rtc_pkg::cfg_index_t'(cfg_index))
        rtc_pkg::CFG_SLAVE_ADDR: slave_addr_r <= cfg_data;
        rtc_pkg::CFG_READ_FC:    read_fc_r    <= cfg_data[6:0];
        rtc_pkg::CFG_WRITE_FC:   write_fc_r   <= cfg_data[6:0];
        rtc_pkg::CFG_EXC_FLAG:   exc_flag_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign addr_cap      = (n == 9'd0) ? in_rx_byte : addr_r;
  assign func_cap      = (n == 9'd1) ? in_rx_byte : func_r;
  assign third_cap     = (n == 9'd2) ? in_rx_byte : third_r;
  assign data_high_cap = (n == 9'd3) ? in_rx_byte : data_high_r;
  assign data_low_cap  = (n == 9'd4) ? in_rx_byte : data_low_r;

  always_comb begin
    if ((func_cap == ({1'b0, read_fc_r} | exc_flag_r)) ||
        (func_cap == ({1'b0, write_fc_r} | exc_flag_r))) begin
      kind = rtc_pkg::KIND_EXC;
    end else if (func_cap == {1'b0, write_fc_r}) begin
      kind = rtc_pkg::KIND_WRITE;
    end else if (func_cap == {1'b0, read_fc_r}) begin
      kind = rtc_pkg::KIND_READ;
    end else begin
      kind = rtc_pkg::KIND_UNKNOWN;
    end
  end

  always_comb begin
    unique case (kind)
      rtc_pkg::KIND_EXC:   len = rtc_pkg::EXC_FRAME_LEN;
      rtc_pkg::KIND_WRITE: len = rtc_pkg::WRITE_FRAME_LEN;
      rtc_pkg::KIND_READ:  len = rtc_pkg::READ_HEADER_LEN + {1'b0, third_cap};
      default:             len = '0;
    endcase
  end

  assign len_m1 = len - 9'd1;
  assign len_m2 = len - 9'd2;
  assign total  = (n == rtc_pkg::COUNT_MAX) ? n : n + 9'd1;

  always_comb begin
    if (n < 9'd3) begin
      act = rtc_pkg::ACT_CRC;
    end else if (kind == rtc_pkg::KIND_UNKNOWN) begin
      act = rtc_pkg::ACT_NONE;
    end else if (n < len_m2) begin
      act = rtc_pkg::ACT_CRC;
    end else if (n == len_m2) begin
      act = rtc_pkg::ACT_HOLD_LO;
    end else if (n == len_m1) begin
      act = rtc_pkg::ACT_HOLD_HI;
    end else begin
      act = rtc_pkg::ACT_NONE;
    end
  end

  always_comb begin
    if (total < rtc_pkg::MIN_FRAME_LEN) begin
      verdict = rtc_pkg::V_SHORT;
    end else if (addr_cap != slave_addr_r) begin
      verdict = rtc_pkg::V_BAD_ADDR;
    end else begin
      unique case (kind)
        rtc_pkg::KIND_EXC:   verdict = rtc_pkg::V_EXC;
        rtc_pkg::KIND_WRITE: verdict = (total < len) ? rtc_pkg::V_SHORT : rtc_pkg::V_WRITE;
        rtc_pkg::KIND_READ:  verdict = (total < len) ? rtc_pkg::V_SHORT : rtc_pkg::V_READ;
        default:             verdict = rtc_pkg::V_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    op_data.rx_byte   = in_rx_byte;
    op_data.act       = act;
    op_data.last      = in_last_byte;
    op_data.verdict   = verdict;
    op_data.third     = third_cap;
    op_data.data_high = data_high_cap;
    op_data.data_low  = data_low_cap;
  end

  assign count_nxt = in_last_byte ? '0 : total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r      <= addr_cap;
      func_r      <= func_cap;
      third_r     <= third_cap;
      data_high_r <= data_high_cap;
      data_low_r  <= data_low_cap;
    end
  end

endmodule

>>> hdl/rtc_back.sv
// Back end: CRC-16 engine, received CRC capture and final status generation.
module rtc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_empty,
  input  rtc_pkg::op_t      op_data,
  output logic              op_pop,
  input  logic              res_full,
  output logic              res_push,
  output rtc_pkg::result_t  res_data
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] held_r, held_nxt;
  logic        take;
  logic        crc_match;

  assign take     = !op_empty && (!op_data.last || !res_full);
  assign op_pop   = take;
  assign res_push = take && op_data.last;

  always_comb begin
    crc_nxt  = crc_r;
    held_nxt = held_r;
    unique case (op_data.act)
      rtc_pkg::ACT_CRC:     crc_nxt  = rtc_pkg::crc16_byte(crc_r, op_data.rx_byte);
      rtc_pkg::ACT_HOLD_LO: held_nxt = {held_r[15:8], op_data.rx_byte};
      rtc_pkg::ACT_HOLD_HI: held_nxt = {op_data.rx_byte, held_r[7:0]};
      default: ;
    endcase
  end

  assign crc_match = (held_nxt == crc_nxt);

  always_comb begin
    res_data.status         = rtc_pkg::ST_UNKNOWN;
    res_data.exception_code = 8'h00;
    res_data.data_high      = 8'h00;
    res_data.data_low       = 8'h00;
    res_data.data_valid     = 1'b0;
    unique case (op_data.verdict)
      rtc_pkg::V_SHORT:    res_data.status = rtc_pkg::ST_SHORT;
      rtc_pkg::V_BAD_ADDR: res_data.status = rtc_pkg::ST_BAD_ADDR;
      rtc_pkg::V_EXC: begin
        if (crc_match) begin
          res_data.status         = rtc_pkg::ST_EXCEPTION;
          res_data.exception_code = op_data.third;
        end else begin
          res_data.status = rtc_pkg::ST_CRC_EXC;
        end
      end
      rtc_pkg::V_WRITE: begin
        res_data.status = crc_match ? rtc_pkg::ST_OK : rtc_pkg::ST_CRC_WRITE;
      end
      rtc_pkg::V_READ: begin
        if (crc_match) begin
          res_data.status     = rtc_pkg::ST_OK;
          res_data.data_high  = op_data.data_high;
          res_data.data_low   = op_data.data_low;
          res_data.data_valid = 1'b1;
        end else begin
          res_data.status = rtc_pkg::ST_CRC_READ;
        end
      end
      default: res_data.status = rtc_pkg::ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= rtc_pkg::CRC_INIT;
      held_r <= '0;
    end else if (take) begin
      if (op_data.last) begin
        crc_r  <= rtc_pkg::CRC_INIT;
        held_r <= '0;
      end else begin
        crc_r  <= crc_nxt;
        held_r <= held_nxt;
      end
    end
  end

endmodule

>>> hdl/rtu_response_checker_crc16.sv
// Top level of the Modbus RTU response checker with CRC-16.
// Throughput: one byte request per cycle while in_full is low, set by the CRC byte step in the
// back end. A last byte accepted into empty queues is written into the request queue, taken by the
// back end and pushed into the result queue that drives the out_ ports. The request queue between
// front and back holds OP_DEPTH bytes; results queue RES_DEPTH deep. Reset is synchronous and
// active low; it empties both queues, clears the byte count and CRC state, and restores the config.
module rtu_response_checker_crc16 #(
  parameter int OP_DEPTH  = rtc_pkg::OP_DEPTH_DEF,
  parameter int RES_DEPTH = rtc_pkg::RES_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_last_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [2:0]                      out_status,
  output logic [7:0]                      out_exception_code,
  output logic [7:0]                      out_data_high,
  output logic [7:0]                      out_data_low,
  output logic                            out_data_valid
);

  rtc_pkg::op_t     op_wr, op_rd;
  rtc_pkg::result_t res_wr, res_rd;
  logic             op_push, op_full, op_pop, op_empty;
  logic             res_push, res_full;

  rtc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_rx_byte   (in_rx_byte),
    .in_last_byte (in_last_byte),
    .op_push      (op_push),
    .op_data      (op_wr),
    .op_full      (op_full)
  );

  rtc_fifo #(
    .WIDTH ($bits(rtc_pkg::op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .wr_data (op_wr),
    .full    (op_full),
    .pop     (op_pop),
    .rd_data (op_rd),
    .empty   (op_empty)
  );

  rtc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_empty (op_empty),
    .op_data  (op_rd),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wr)
  );

  rtc_fifo #(
    .WIDTH ($bits(rtc_pkg::result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

  assign out_status         = res_rd.status;
  assign out_exception_code = res_rd.exception_code;
  assign out_data_high      = res_rd.data_high;
  assign out_data_low       = res_rd.data_low;
  assign out_data_valid     = res_rd.data_valid;

`ifndef ASSERT_OFF
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("Result pushed into a full result queue.");

  a_last_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_last_byte && op_empty && out_empty) |=> ##1 !out_empty)
    else $error("Last byte did not produce a result within two cycles.");

  a_valid_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_wr.data_valid) |-> (res_wr.status == rtc_pkg::ST_OK && op_rd.last))
    else $error("Read data flagged valid on a result that is not OK.");
`endif

endmodule
